/* rtl/core/rigid_body_kinematic_step_top_macros.svh */
// Assertion macros for the rigid body kinematic step block
`ifndef RIGID_BODY_KINEMATIC_STEP_TOP_MACROS_SVH
`define RIGID_BODY_KINEMATIC_STEP_TOP_MACROS_SVH

// same-cycle implication
`define RBK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbk assertion failed");

// next-cycle implication
`define RBK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbk assertion failed");

`endif

/* rtl/core/rbk_pkg.sv */
// Shared types, codes and helpers for the rigid body kinematic step block
package rbk_pkg;

  localparam int QW = 32;
  localparam int PW = 66;

  localparam logic [1:0] REG_MASS      = 2'd0;
  localparam logic [1:0] REG_SPEED_LIM = 2'd1;
  localparam logic [1:0] REG_ROT_LIM   = 2'd2;
  localparam logic [1:0] REG_ANG_ACC   = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FDIV_START, OP_FDIV_WR, OP_MUL_AD, OP_MUL_VD, OP_MUL_DVD,
    OP_UPD_AXIS, OP_MUL_HD, OP_UPD_H, OP_UPD_S, OP_SQ, OP_LIM, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_MUL_SC, OP_SDIV_START, OP_SC_WR, OP_CLAMP, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FDIV, ST_FWAIT, ST_FWR, ST_MAD, ST_MVD, ST_MDVD, ST_UPD, ST_MHD,
    ST_UPH, ST_UPS, ST_SQ, ST_LIM, ST_CMP, ST_SQI, ST_SQS, ST_SCM, ST_SDIV,
    ST_SWAIT, ST_SWR, ST_CLAMP, ST_DONE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sum_gt;
  } stat_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] v);
    if (v[PW-1:QW-1] == {(PW-QW+1){v[PW-1]}}) begin
      return v[QW-1:0];
    end
    return v[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [PW-1:0] ext66(input logic signed [QW-1:0] v);
    return {{(PW-QW){v[QW-1]}}, v};
  endfunction

endpackage

/* rtl/core/rbk_div.sv */
// Shared restoring divider, 64 by 32 bits unsigned, one quotient bit per cycle
module rbk_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvsr;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial    = {rem, quo[63]};
  assign ge       = trial >= {1'b0, dvsr};
  assign diff     = trial - {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

/* rtl/core/rbk_ctrl.sv */
// Sequencer for force and time step items
module rbk_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          s_tuser,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  rbk_pkg::stat_t stat,
  output rbk_pkg::cmd_t  cmd
);

  rbk_pkg::state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic [4:0] cnt, cnt_next;
  logic       out_valid, out_valid_next;

  assign s_tready = (state == rbk_pkg::ST_IDLE);
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rbk_pkg::ST_IDLE;
      axis      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    cnt_next       = cnt;
    out_valid_next = out_valid & ~m_tready;
    cmd.op         = rbk_pkg::OP_NONE;
    cmd.axis       = axis;
    unique case (state)
      rbk_pkg::ST_IDLE: begin
        axis_next = '0;
        if (s_tvalid) begin
          cmd.op     = rbk_pkg::OP_LOAD;
          state_next = s_tuser ? rbk_pkg::ST_MAD : rbk_pkg::ST_FDIV;
        end
      end
      rbk_pkg::ST_FDIV: begin
        cmd.op     = rbk_pkg::OP_FDIV_START;
        state_next = rbk_pkg::ST_FWAIT;
      end
      rbk_pkg::ST_FWAIT: begin
        if (stat.div_done) state_next = rbk_pkg::ST_FWR;
      end
      rbk_pkg::ST_FWR: begin
        cmd.op = rbk_pkg::OP_FDIV_WR;
        if (axis == 2'd2) begin
          state_next = rbk_pkg::ST_DONE;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = rbk_pkg::ST_FDIV;
        end
      end
      rbk_pkg::ST_MAD: begin
        cmd.op     = rbk_pkg::OP_MUL_AD;
        state_next = rbk_pkg::ST_MVD;
      end
      rbk_pkg::ST_MVD: begin
        cmd.op     = rbk_pkg::OP_MUL_VD;
        state_next = rbk_pkg::ST_MDVD;
      end
      rbk_pkg::ST_MDVD: begin
        cmd.op     = rbk_pkg::OP_MUL_DVD;
        state_next = rbk_pkg::ST_UPD;
      end
      rbk_pkg::ST_UPD: begin
        cmd.op = rbk_pkg::OP_UPD_AXIS;
        if (axis == 2'd2) begin
          state_next = rbk_pkg::ST_MHD;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = rbk_pkg::ST_MAD;
        end
      end
      rbk_pkg::ST_MHD: begin
        cmd.op     = rbk_pkg::OP_MUL_HD;
        state_next = rbk_pkg::ST_UPH;
      end
      rbk_pkg::ST_UPH: begin
        cmd.op     = rbk_pkg::OP_UPD_H;
        state_next = rbk_pkg::ST_UPS;
      end
      rbk_pkg::ST_UPS: begin
        cmd.op     = rbk_pkg::OP_UPD_S;
        axis_next  = '0;
        state_next = rbk_pkg::ST_SQ;
      end
      rbk_pkg::ST_SQ: begin
        cmd.op = rbk_pkg::OP_SQ;
        if (axis == 2'd2) begin
          state_next = rbk_pkg::ST_LIM;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      rbk_pkg::ST_LIM: begin
        cmd.op     = rbk_pkg::OP_LIM;
        state_next = rbk_pkg::ST_CMP;
      end
      rbk_pkg::ST_CMP: begin
        state_next = stat.sum_gt ? rbk_pkg::ST_SQI : rbk_pkg::ST_CLAMP;
      end
      rbk_pkg::ST_SQI: begin
        cmd.op     = rbk_pkg::OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = rbk_pkg::ST_SQS;
      end
      rbk_pkg::ST_SQS: begin
        cmd.op   = rbk_pkg::OP_SQRT_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) begin
          axis_next  = '0;
          state_next = rbk_pkg::ST_SCM;
        end
      end
      rbk_pkg::ST_SCM: begin
        cmd.op     = rbk_pkg::OP_MUL_SC;
        state_next = rbk_pkg::ST_SDIV;
      end
      rbk_pkg::ST_SDIV: begin
        cmd.op     = rbk_pkg::OP_SDIV_START;
        state_next = rbk_pkg::ST_SWAIT;
      end
      rbk_pkg::ST_SWAIT: begin
        if (stat.div_done) state_next = rbk_pkg::ST_SWR;
      end
      rbk_pkg::ST_SWR: begin
        cmd.op = rbk_pkg::OP_SC_WR;
        if (axis == 2'd2) begin
          state_next = rbk_pkg::ST_CLAMP;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = rbk_pkg::ST_SCM;
        end
      end
      rbk_pkg::ST_CLAMP: begin
        cmd.op     = rbk_pkg::OP_CLAMP;
        state_next = rbk_pkg::ST_DONE;
      end
      rbk_pkg::ST_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.op         = rbk_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = rbk_pkg::ST_IDLE;
        end
      end
      default: state_next = rbk_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/rbk_dpath.sv */
// Datapath: body state, settings, shared multiplier, divider and root step
module rbk_dpath (
  input  logic           clk,
  input  logic           rst,
  input  rbk_pkg::cmd_t  cmd,
  output rbk_pkg::stat_t stat,
  input  logic [127:0]   s_tdata,
  output logic [255:0]   m_tdata,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int PW = rbk_pkg::PW;

  logic [30:0]        mass;
  logic [30:0]        speed_lim;
  logic signed [31:0] rot_lim;
  logic signed [31:0] ang_acc;

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] acc [3];
  logic signed [31:0] heading;
  logic signed [31:0] spin;

  logic signed [31:0] force_in [3];
  logic [30:0]        dt;
  logic signed [PW-1:0] prod;
  logic signed [31:0] dv_reg;
  logic signed [47:0] pv_reg;
  logic [63:0]        sum;
  logic [63:0]        sq_n;
  logic [63:0]        sq_res;
  logic [63:0]        sq_bit;
  logic [255:0]       out_data;

  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] dt_ext;
  logic signed [31:0] v_ax, f_ax;
  logic [31:0]        abs_v, abs_f;
  logic               div_start, div_done;
  logic [63:0]        dividend, quotient;
  logic [31:0]        divisor;
  logic signed [PW-1:0] q_s, pos_sum, vel_sum;
  logic [63:0]        sq_t;

  assign dt_ext  = $signed({2'b00, dt});
  assign v_ax    = vel[cmd.axis];
  assign f_ax    = force_in[cmd.axis];
  assign abs_v   = v_ax[31] ? 32'(-v_ax) : v_ax;
  assign abs_f   = f_ax[31] ? 32'(-f_ax) : f_ax;
  assign q_s     = $signed({2'b00, quotient});
  assign pos_sum = rbk_pkg::ext66(pos[cmd.axis]) + $signed({{(PW-48){pv_reg[47]}}, pv_reg})
                   + (prod >>> 17);
  assign vel_sum = rbk_pkg::ext66(v_ax) + rbk_pkg::ext66(dv_reg);
  assign sq_t    = sq_res + sq_bit;

  assign stat.div_done = div_done;
  assign stat.sum_gt   = sum > prod[63:0];
  assign m_tdata       = out_data;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      rbk_pkg::OP_MUL_AD:  begin mul_a = 33'(acc[cmd.axis]); mul_b = dt_ext; end
      rbk_pkg::OP_MUL_VD:  begin mul_a = 33'(v_ax);          mul_b = dt_ext; end
      rbk_pkg::OP_MUL_DVD: begin mul_a = 33'(dv_reg);        mul_b = dt_ext; end
      rbk_pkg::OP_MUL_HD:  begin mul_a = 33'(spin);          mul_b = dt_ext; end
      rbk_pkg::OP_UPD_H:   begin mul_a = 33'(ang_acc);       mul_b = dt_ext; end
      rbk_pkg::OP_SQ:      begin mul_a = 33'(v_ax);          mul_b = 33'(v_ax); end
      rbk_pkg::OP_LIM: begin
        mul_a = $signed({2'b00, speed_lim});
        mul_b = $signed({2'b00, speed_lim});
      end
      rbk_pkg::OP_MUL_SC: begin
        mul_a = $signed({1'b0, abs_v});
        mul_b = $signed({2'b00, speed_lim});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    dividend  = prod[63:0];
    divisor   = sq_res[31:0];
    if (cmd.op == rbk_pkg::OP_FDIV_START) begin
      div_start = 1'b1;
      dividend  = {16'h0000, abs_f, 16'h0000};
      divisor   = {1'b0, mass};
    end else if (cmd.op == rbk_pkg::OP_SDIV_START) begin
      div_start = 1'b1;
    end
  end

  rbk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mass      <= 31'd65536;
      speed_lim <= 31'd65536;
      rot_lim   <= 32'sd65536;
      ang_acc   <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbk_pkg::REG_MASS:      mass      <= cfg_data[30:0];
        rbk_pkg::REG_SPEED_LIM: speed_lim <= cfg_data[30:0];
        rbk_pkg::REG_ROT_LIM:   rot_lim   <= cfg_data;
        rbk_pkg::REG_ANG_ACC:   ang_acc   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        acc[i] <= '0;
      end
      heading <= '0;
      spin    <= '0;
    end else begin
      unique case (cmd.op)
        rbk_pkg::OP_FDIV_WR: begin
          if (mass == '0) begin
            acc[cmd.axis] <= f_ax[31] ? 32'sh8000_0000 :
                             (f_ax == '0) ? 32'sd0 : 32'sh7fff_ffff;
          end else begin
            acc[cmd.axis] <= rbk_pkg::sat32(f_ax[31] ? -q_s : q_s);
          end
        end
        rbk_pkg::OP_UPD_AXIS: begin
          pos[cmd.axis] <= rbk_pkg::sat32(pos_sum);
          vel[cmd.axis] <= rbk_pkg::sat32(vel_sum);
        end
        rbk_pkg::OP_UPD_H: heading <= rbk_pkg::sat32(rbk_pkg::ext66(heading) + (prod >>> 16));
        rbk_pkg::OP_UPD_S: spin <= rbk_pkg::sat32(rbk_pkg::ext66(spin) + (prod >>> 16));
        rbk_pkg::OP_SC_WR: vel[cmd.axis] <= rbk_pkg::sat32(v_ax[31] ? -q_s : q_s);
        rbk_pkg::OP_CLAMP: begin
          if (spin > rot_lim) spin <= rot_lim;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      rbk_pkg::OP_LOAD: begin
        force_in[0] <= s_tdata[31:0];
        force_in[1] <= s_tdata[63:32];
        force_in[2] <= s_tdata[95:64];
        dt          <= s_tdata[126:96];
      end
      rbk_pkg::OP_MUL_VD:  dv_reg <= rbk_pkg::sat32(prod >>> 16);
      rbk_pkg::OP_MUL_DVD: pv_reg <= 48'(prod >>> 16);
      rbk_pkg::OP_SQ:      sum <= (cmd.axis == 2'd0) ? 64'd0 : sum + prod[63:0];
      rbk_pkg::OP_LIM:     sum <= sum + prod[63:0];
      rbk_pkg::OP_SQRT_INIT: begin
        sq_n   <= sum;
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      rbk_pkg::OP_SQRT_STEP: begin
        if (sq_n >= sq_t) begin
          sq_n   <= sq_n - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      rbk_pkg::OP_EMIT: begin
        out_data <= {spin, heading, vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/rigid_body_kinematic_step_top.sv */
// Top level of the rigid body kinematic step block
//
// Input stream s_*: one word per item. s_tuser selects the item kind
// (0 = apply force, 1 = advance by time step). Output stream m_*: one
// word per item carrying the body state after that item.
// Settings port cfg_*: cfg_we writes cfg_data to register cfg_index
// (0 mass, 1 speed limit, 2 rotation limit, 3 angular acceleration).
// One item is in work at a time; s_tready is high only when idle.
// A force item makes three passes of the shared one-bit-per-cycle
// divider. A time step runs on the shared multiplier and, when the
// speed clamp fires, adds 32 root steps and three divider passes.
// The result sits in an output register; the block goes back to idle
// and takes the next item while it waits. If the receiver stalls, the
// next result is held until the previous word is taken.
// Reset (rst, synchronous) zeroes the body state, restores the register
// defaults and drops any pending output word.
module rigid_body_kinematic_step_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // force_x, force_y, force_z, time_step, pad
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata,   // pos_x/y/z, vel_x/y/z, heading, spin_rate
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  `include "rigid_body_kinematic_step_top_macros.svh"

  rbk_pkg::cmd_t  cmd;
  rbk_pkg::stat_t stat;

  rbk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbk_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  `RBK_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `RBK_ASSERT_NXT(a_emit_shows_word, cmd.op == rbk_pkg::OP_EMIT, m_tvalid)
  `RBK_ASSERT_IMP(a_emit_only_when_free, cmd.op == rbk_pkg::OP_EMIT, !m_tvalid || m_tready)

endmodule
